/* rtl/core/pap_pkg.sv */
// Package for the pulsed axis positioner: payload structs, configuration
// struct, command, direction and status codes.
// No dependencies.
package pap_pkg;

  localparam int ANGLE_W = 16;
  localparam int TICK_W  = 16;
  localparam int DUTY_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_RUN_UP     = 3'd1,
    OP_RUN_DOWN   = 3'd2,
    OP_STOP       = 3'd3,
    OP_PULSE_UP   = 3'd4,
    OP_PULSE_DOWN = 3'd5,
    OP_MOVE       = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    HEAD_STOP = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } heading_e;

  typedef enum logic [2:0] {
    MS_NONE    = 3'd0,
    MS_REACHED = 3'd1,
    MS_BUSY    = 3'd2,
    MS_BLOCKED = 3'd3,
    MS_STARTED = 3'd4
  } move_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_LIMIT = 3'd0,
    REG_UPPER_LIMIT = 3'd1,
    REG_SLOW_BAND   = 3'd2,
    REG_SLOW_PULSE  = 3'd3,
    REG_FAST_PULSE  = 3'd4,
    REG_SLOW_DUTY   = 3'd5,
    REG_FAST_DUTY   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]                op;
    logic [TICK_W-1:0]         pulse_length;
    logic [DUTY_W-1:0]         pulse_duty;
    logic signed [ANGLE_W-1:0] measured_angle;
    logic signed [ANGLE_W-1:0] target_angle;
    logic [ANGLE_W-1:0]        tolerance;
    logic                      use_limits;
  } in_item_t;

  typedef struct packed {
    logic              bridge_in1;
    logic              bridge_in2;
    logic [DUTY_W-1:0] drive_duty;
    logic [1:0]        motion;
    logic              pulse_running;
    logic [2:0]        move_status;
    logic              angle_in_limits;
  } out_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] lower_soft_limit;
    logic signed [ANGLE_W-1:0] upper_soft_limit;
    logic [ANGLE_W-1:0]        slow_band;
    logic [TICK_W-1:0]         slow_pulse_ms;
    logic [TICK_W-1:0]         fast_pulse_ms;
    logic [DUTY_W-1:0]         slow_duty;
    logic [DUTY_W-1:0]         fast_duty;
  } cfg_t;

endpackage

/* rtl/core/pap_cfg_regs.sv */
// Configuration register bank of the pulsed axis positioner.
// Depends on pap_pkg.
module pap_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pap_pkg::CFG_W-1:0]      cfg_wdata_i,
  output pap_pkg::cfg_t                  cfg_o
);
  import pap_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOWER_LIMIT: cfg_d.lower_soft_limit = cfg_wdata_i[ANGLE_W-1:0];
        REG_UPPER_LIMIT: cfg_d.upper_soft_limit = cfg_wdata_i[ANGLE_W-1:0];
        REG_SLOW_BAND:   cfg_d.slow_band        = cfg_wdata_i[ANGLE_W-1:0];
        REG_SLOW_PULSE:  cfg_d.slow_pulse_ms    = cfg_wdata_i[TICK_W-1:0];
        REG_FAST_PULSE:  cfg_d.fast_pulse_ms    = cfg_wdata_i[TICK_W-1:0];
        REG_SLOW_DUTY:   cfg_d.slow_duty        = cfg_wdata_i[DUTY_W-1:0];
        REG_FAST_DUTY:   cfg_d.fast_duty        = cfg_wdata_i[DUTY_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_soft_limit <= ANGLE_W'(0);
      cfg_q.upper_soft_limit <= ANGLE_W'(9000);
      cfg_q.slow_band        <= ANGLE_W'(300);
      cfg_q.slow_pulse_ms    <= TICK_W'(80);
      cfg_q.fast_pulse_ms    <= TICK_W'(200);
      cfg_q.slow_duty        <= DUTY_W'(150);
      cfg_q.fast_duty        <= DUTY_W'(255);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/pap_ctrl.sv */
// Pulse and direction state of the axis plus the per-command decision logic.
// Depends on pap_pkg.
module pap_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pap_pkg::in_item_t   item_i,
  input  pap_pkg::cfg_t       cfg_i,
  output pap_pkg::out_item_t  result_o
);
  import pap_pkg::*;

  logic              pulse_on_q, pulse_on_d;
  logic [TICK_W-1:0] target_q, target_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic [1:0]        heading_q, heading_d;
  logic [DUTY_W-1:0] duty_q, duty_d;

  logic signed [ANGLE_W:0] err;
  logic [ANGLE_W:0]        mag;
  logic [ANGLE_W:0]        neg_err;
  logic                    err_neg, err_pos;
  logic                    within_tol, slow, at_lower, at_upper;
  logic [TICK_W-1:0]       elapsed_inc;
  logic [2:0]              status;

  assign err = {item_i.target_angle[ANGLE_W-1], item_i.target_angle}
             - {item_i.measured_angle[ANGLE_W-1], item_i.measured_angle};
  assign neg_err    = (ANGLE_W+1)'(0) - err;
  assign err_neg    = err[ANGLE_W];
  assign err_pos    = !err_neg && (err != '0);
  assign mag        = err_neg ? neg_err : err;
  assign within_tol = mag <= {1'b0, item_i.tolerance};
  assign slow       = mag <= {1'b0, cfg_i.slow_band};
  assign at_lower   = item_i.measured_angle <= cfg_i.lower_soft_limit;
  assign at_upper   = item_i.measured_angle >= cfg_i.upper_soft_limit;
  // The elapsed count saturates instead of wrapping.
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);

  always_comb begin
    pulse_on_d = pulse_on_q;
    target_d   = target_q;
    elapsed_d  = elapsed_q;
    heading_d  = heading_q;
    duty_d     = duty_q;
    status     = MS_NONE;
    case (item_i.op)
      OP_TICK: begin
        if (pulse_on_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= target_q) begin
            pulse_on_d = 1'b0;
            target_d   = '0;
            heading_d  = HEAD_STOP;
            duty_d     = '0;
          end
        end
      end
      OP_RUN_UP, OP_RUN_DOWN: begin
        pulse_on_d = 1'b0;
        target_d   = '0;
        heading_d  = (item_i.op == OP_RUN_UP) ? HEAD_UP : HEAD_DOWN;
        duty_d     = cfg_i.fast_duty;
      end
      OP_STOP: begin
        pulse_on_d = 1'b0;
        target_d   = '0;
        heading_d  = HEAD_STOP;
        duty_d     = '0;
      end
      OP_PULSE_UP, OP_PULSE_DOWN: begin
        elapsed_d  = '0;
        target_d   = item_i.pulse_length;
        pulse_on_d = 1'b1;
        heading_d  = (item_i.op == OP_PULSE_UP) ? HEAD_UP : HEAD_DOWN;
        duty_d     = item_i.pulse_duty;
      end
      OP_MOVE: begin
        if (pulse_on_q) begin
          // Only the end condition is checked; the count does not advance.
          status = MS_BUSY;
          if (elapsed_q >= target_q) begin
            pulse_on_d = 1'b0;
            target_d   = '0;
            heading_d  = HEAD_STOP;
            duty_d     = '0;
          end
        end else if (within_tol || (item_i.use_limits &&
                     ((at_lower && err_neg) || (at_upper && err_pos)))) begin
          status     = within_tol ? MS_REACHED : MS_BLOCKED;
          pulse_on_d = 1'b0;
          target_d   = '0;
          heading_d  = HEAD_STOP;
          duty_d     = '0;
        end else begin
          status     = MS_STARTED;
          elapsed_d  = '0;
          target_d   = slow ? cfg_i.slow_pulse_ms : cfg_i.fast_pulse_ms;
          pulse_on_d = 1'b1;
          heading_d  = err_pos ? HEAD_UP : HEAD_DOWN;
          duty_d     = slow ? cfg_i.slow_duty : cfg_i.fast_duty;
        end
      end
      default: begin
        status = MS_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_on_q <= 1'b0;
      target_q   <= '0;
      elapsed_q  <= '0;
      heading_q  <= HEAD_STOP;
      duty_q     <= '0;
    end else if (step_i) begin
      pulse_on_q <= pulse_on_d;
      target_q   <= target_d;
      elapsed_q  <= elapsed_d;
      heading_q  <= heading_d;
      duty_q     <= duty_d;
    end
  end

  // Semantic up drives input two of the bridge, semantic down input one.
  always_comb begin
    result_o.bridge_in1      = heading_d == HEAD_DOWN;
    result_o.bridge_in2      = heading_d == HEAD_UP;
    result_o.drive_duty      = duty_d;
    result_o.motion          = heading_d;
    result_o.pulse_running   = pulse_on_d;
    result_o.move_status     = status;
    result_o.angle_in_limits = (item_i.measured_angle >= cfg_i.lower_soft_limit)
                            && (item_i.measured_angle <= cfg_i.upper_soft_limit);
  end

endmodule

/* rtl/core/pulsed_axis_positioner.sv */
// Pulsed axis positioner top level: request register, control step, result register.
// Throughput 1 request per cycle while the output is not stalled. The input stalls
// only while both registers are full and the output is stalled. Reset (asynchronous,
// active low) stops the axis, clears the pulse state, empties both registers and
// loads the configuration defaults.
module pulsed_axis_positioner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pap_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pap_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pap_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pap_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import pap_pkg::*;

  cfg_t      cfg;
  in_item_t  req_q;
  logic      req_valid_q;
  out_item_t res_q, res_d;
  logic      res_valid_q;
  logic      advance, accept, step;

  // The request register moves on whenever the result register is free or drained.
  assign advance    = !res_valid_q || !out_stall_i;
  assign in_stall_o = req_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = req_valid_q && advance;

  pap_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pap_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (req_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // An empty request register takes a new request even while the output is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        res_valid_q <= req_valid_q;
      end
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (step) begin
        req_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule
